// ----- sv/dmpt_pkg.sv -----
`default_nettype none
package dmpt_pkg;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned DEPTH_W = 8;
  localparam int unsigned SID_W   = 16;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned SCORE_W = 16;
  localparam int unsigned MOVE_W  = 16;
  localparam int unsigned COUNT_W = 13;

  // Replacement rule thresholds
  localparam logic [DEPTH_W-1:0] DEPTH_FLOOR  = 8'd5;
  localparam logic [DEPTH_W:0]   DEPTH_MARGIN = 9'd2;
  localparam logic [SID_W:0]     AGE_WINDOW   = 17'd2;
  localparam logic [COUNT_W-1:0] FILLED_MAX   = 13'd8191;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_STORE  = 1'b1;

  typedef struct packed {
    logic                      op;
    logic [KEY_W-1:0]          position_key;
    logic [DEPTH_W-1:0]        search_depth;
    logic [SID_W-1:0]          search_number;
    logic [KIND_W-1:0]         bound_kind;
    logic signed [SCORE_W-1:0] score;
    logic [MOVE_W-1:0]         move_code;
  } in_item_t;

  typedef struct packed {
    logic                      hit;
    logic                      accepted;
    logic [KIND_W-1:0]         found_kind;
    logic [DEPTH_W-1:0]        found_depth;
    logic signed [SCORE_W-1:0] found_score;
    logic [MOVE_W-1:0]         found_move;
    logic [COUNT_W-1:0]        slots_filled;
  } out_item_t;

  typedef struct packed {
    logic                      valid;
    logic [KEY_W-1:0]          tag;
    logic [DEPTH_W-1:0]        depth;
    logic [KIND_W-1:0]         kind;
    logic signed [SCORE_W-1:0] score;
    logic [MOVE_W-1:0]         move;
    logic [SID_W-1:0]          age;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_FIX,
    ST_READ,
    ST_EVAL
  } state_t;

endpackage
`default_nettype wire

// ----- sv/dmpt_ram.sv -----
`default_nettype none
module dmpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- sv/direct_mapped_position_table_core.sv -----
// Flow: when TABLE_ENTRIES is a power of two, the slot is read, then evaluated
//   and written back; otherwise the key is first reduced 16 bits at a time,
//   an estimate then a fix step per digit. A new request is taken only in idle,
//   after the last one's slot read and write-back; a held result delays both.
// Reset: synchronous active low; afterwards a clearing pass zeroes every slot
//   in turn, with in_ready low until it completes.
`default_nettype none
module direct_mapped_position_table_core
  import dmpt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 4096
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam bit          POW2  = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);
  localparam int unsigned ENTRY_W = $bits(entry_t);
  // key reduction: 16-bit digits, quotient digit by reciprocal estimate
  localparam int unsigned DIG_W = 16;
  localparam int unsigned V_W   = IDX_W + DIG_W;
  localparam logic [V_W-1:0] M_V   = V_W'(TABLE_ENTRIES);
  localparam logic [DIG_W:0] RECIP = (DIG_W + 1)'((64'd1 << V_W) / 64'(TABLE_ENTRIES));

  state_t             state_r, state_nxt;
  in_item_t           req_r, req_nxt;          // request being worked on
  logic [IDX_W-1:0]   idx_r, idx_nxt;          // slot index / running remainder
  logic [1:0]         dig_cnt_r, dig_cnt_nxt;  // key digit for reduction
  logic [DIG_W-1:0]   quo_r, quo_nxt;          // estimated quotient digit
  logic [IDX_W-1:0]   clr_idx_r, clr_idx_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;

  // memory port
  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wdata, ram_rdata;

  // read-modify-write evaluation
  logic               tag_match, deep_enough, hit;
  logic               protect_depth, protect_age, refuse;
  logic               out_free;

  // key reduction datapath
  logic [DIG_W-1:0]   mod_digit;
  logic [V_W-1:0]     mod_v, mod_qm, mod_rem;
  logic [V_W+DIG_W:0] mod_prod;
  logic [DIG_W-1:0]   mod_quo;

  dmpt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      dig_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      dig_cnt_r   <= dig_cnt_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    idx_r      <= idx_nxt;
    quo_r      <= quo_nxt;
    out_item_r <= out_item_nxt;
  end

  // slot evaluation on the registered read data
  always_comb begin
    tag_match     = ram_rdata.valid && (ram_rdata.tag == req_r.position_key);
    deep_enough   = ram_rdata.depth >= req_r.search_depth;
    hit           = tag_match && deep_enough;
    // refuse: deep stored entry, new one clearly shallower, and recent age
    protect_depth = (ram_rdata.depth > DEPTH_FLOOR) &&
                    (({1'b0, req_r.search_depth} + DEPTH_MARGIN) <=
                     {1'b0, ram_rdata.depth});
    // sid - age < 2, unwrapped, as sid < age + 2
    protect_age   = {1'b0, req_r.search_number} < ({1'b0, ram_rdata.age} + AGE_WINDOW);
    refuse        = ram_rdata.valid && protect_depth && protect_age;
  end

  // r = (r * 2^16 + digit) mod N; the reciprocal estimate is low by at most
  // one, so one conditional subtract finishes the step
  always_comb begin
    mod_digit = req_r.position_key[{dig_cnt_r, 4'b0000} +: DIG_W];
    mod_v     = {idx_r, mod_digit};
    mod_prod  = {{(DIG_W + 1){1'b0}}, mod_v} * {{V_W{1'b0}}, RECIP};
    mod_quo   = mod_prod[V_W +: DIG_W];
    mod_qm    = {{IDX_W{1'b0}}, quo_r} * M_V;
    mod_rem   = mod_v - mod_qm;
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    idx_nxt       = idx_r;
    dig_cnt_nxt   = dig_cnt_r;
    quo_nxt       = quo_r;
    clr_idx_nxt   = clr_idx_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = '0;
    in_ready      = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        // zero one slot a cycle; valid bit ends up clear
        ram_we      = 1'b1;
        ram_waddr   = clr_idx_r;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == IDX_LAST) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt = in_item;
          if (POW2) begin
            idx_nxt   = in_item.position_key[IDX_W-1:0] & IDX_LAST;
            state_nxt = ST_READ;
          end else begin
            idx_nxt     = '0;
            dig_cnt_nxt = 2'd3;
            state_nxt   = ST_MOD;
          end
        end
      end

      ST_MOD: begin
        // quotient digit estimate
        quo_nxt   = mod_quo;
        state_nxt = ST_FIX;
      end

      ST_FIX: begin
        if (mod_rem >= M_V) begin
          idx_nxt = IDX_W'(mod_rem - M_V);
        end else begin
          idx_nxt = mod_rem[IDX_W-1:0];
        end
        dig_cnt_nxt = dig_cnt_r - 1'b1;
        if (dig_cnt_r == 2'd0) begin
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_MOD;
        end
      end

      ST_READ: begin
        ram_re    = 1'b1;
        state_nxt = ST_EVAL;
      end

      ST_EVAL: begin
        // read data holds while the result register is blocked
        if (out_free) begin
          out_item_nxt = '0;
          if (req_r.op == OP_LOOKUP) begin
            if (hit) begin
              ram_we                   = 1'b1;
              ram_wdata                = ram_rdata;
              ram_wdata.age            = req_r.search_number;
              out_item_nxt.hit         = 1'b1;
              out_item_nxt.found_kind  = ram_rdata.kind;
              out_item_nxt.found_depth = ram_rdata.depth;
              out_item_nxt.found_score = ram_rdata.score;
              out_item_nxt.found_move  = ram_rdata.move;
            end
          end else begin
            if (!ram_rdata.valid && (count_r != FILLED_MAX)) begin
              count_nxt = count_r + 1'b1;
            end
            if (!refuse) begin
              ram_we                 = 1'b1;
              ram_wdata.valid        = 1'b1;
              ram_wdata.tag          = req_r.position_key;
              ram_wdata.depth        = req_r.search_depth;
              ram_wdata.kind         = req_r.bound_kind;
              ram_wdata.score        = req_r.score;
              ram_wdata.move         = req_r.move_code;
              ram_wdata.age          = req_r.search_number;
              out_item_nxt.accepted  = 1'b1;
            end
          end
          out_item_nxt.slots_filled = count_nxt;
          out_valid_nxt             = 1'b1;
          state_nxt                 = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import dmpt_pkg::*;

  localparam int unsigned SLOT_COUNT       = 4096;
  localparam int          RANDOM_REQUESTS  = 400;
  localparam int          KEY_POOL_SIZE    = 16;
  localparam int          TAIL_REQUESTS    = 40;    // no idling once this few remain
  localparam int          LONG_HOLD_AT     = 150;   // results seen before the long stall
  localparam int          LONG_HOLD_CYCLES = 80;
  localparam int          DRAIN_CYCLES     = 12;    // extra wait after the last expected result
  localparam int          IDLE_LIMIT       = 20000; // well above the length of the clearing pass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  direct_mapped_position_table_core #(
    .TABLE_ENTRIES(SLOT_COUNT)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  // Requests waiting to be driven, and results predicted for accepted requests.
  in_item_t  pending_requests[$];
  out_item_t expected_results[$];

  // Mirror of the slot memory, updated as each request is accepted.
  bit               mirror_valid[SLOT_COUNT];
  entry_t           mirror_slot[SLOT_COUNT];
  logic [COUNT_W-1:0] mirror_filled;

  int total_requests;
  int accepted_count;
  int results_seen;
  int mismatch_count;
  int hit_count, miss_count, write_count, refuse_count;

  int        send_gap;
  int        stall_left;
  bit        long_hold_done;
  int        idle_cycles;
  out_item_t oldest_result;

  // Near the end of the stimulus both sides run flat out.
  function automatic bit quiet_tail();
    return pending_requests.size() < TAIL_REQUESTS;
  endfunction

  function automatic in_item_t make_request(logic op, logic [KEY_W-1:0] key, int depth,
                                            int sid, int kind, int score, int move);
    in_item_t req;
    req.op            = op;
    req.position_key  = key;
    req.search_depth  = 8'(depth);
    req.search_number = 16'(sid);
    req.bound_kind    = 2'(kind);
    req.score         = 16'(score);
    req.move_code     = 16'(move);
    return req;
  endfunction

  // Lookup / store against the mirror; returns the one result the request causes.
  function automatic out_item_t predict_table_access(in_item_t req);
    out_item_t   res;
    int unsigned idx;
    entry_t      cur;
    int          old_depth, new_depth, sid_now, age_then;
    bit          keep_old;
    res = '0;
    idx = 32'(req.position_key % 64'(SLOT_COUNT));
    cur = mirror_slot[idx];
    if (req.op == OP_LOOKUP) begin
      if (mirror_valid[idx] && cur.tag == req.position_key &&
          cur.depth >= req.search_depth) begin
        res.hit         = 1'b1;
        res.found_kind  = cur.kind;
        res.found_depth = cur.depth;
        res.found_score = cur.score;
        res.found_move  = cur.move;
        mirror_slot[idx].age = req.search_number;  // hit refreshes the age
        hit_count++;
      end else begin
        miss_count++;
      end
    end else begin
      keep_old = 1'b0;
      if (!mirror_valid[idx]) begin
        if (mirror_filled < FILLED_MAX) mirror_filled++;
      end else begin
        old_depth = int'(cur.depth);
        new_depth = int'(req.search_depth);
        sid_now   = int'(req.search_number);
        age_then  = int'(cur.age);
        // deep, clearly deeper than the newcomer, and recent: keep it.
        // Age difference is a plain signed subtraction, no 16-bit wrap.
        if (old_depth > int'(DEPTH_FLOOR) &&
            new_depth + int'(DEPTH_MARGIN) <= old_depth &&
            sid_now - age_then < int'(AGE_WINDOW))
          keep_old = 1'b1;
      end
      if (keep_old) begin
        refuse_count++;
      end else begin
        mirror_valid[idx]      = 1'b1;
        mirror_slot[idx].valid = 1'b1;
        mirror_slot[idx].tag   = req.position_key;
        mirror_slot[idx].depth = req.search_depth;
        mirror_slot[idx].kind  = req.bound_kind;
        mirror_slot[idx].score = req.score;
        mirror_slot[idx].move  = req.move_code;
        mirror_slot[idx].age   = req.search_number;
        res.accepted = 1'b1;
        write_count++;
      end
    end
    res.slots_filled = mirror_filled;
    return res;
  endfunction

  task automatic check_field(input string field_name, input longint want, input longint got);
    if (want != got) begin
      mismatch_count++;
      $error("%s: expected %0d, actual %0d", field_name, want, got);
    end
  endtask

  // Driver: presents queued requests, predicts each one as it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_item  <= '0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_table_access(in_item));
        accepted_count++;
      end
      // a held request stays put until taken
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap--;
        end else if (pending_requests.size() != 0 && !quiet_tail() &&
                     $urandom_range(0, 5) == 0) begin
          in_valid <= 1'b0;
          send_gap = $urandom_range(0, 4);  // idle burst of random length
        end else if (pending_requests.size() != 0) begin
          in_item  <= pending_requests.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor / receiver: checks results in order, stalls at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $error("result with no request outstanding");
        end else begin
          oldest_result = expected_results.pop_front();
          check_field("hit", longint'(oldest_result.hit), longint'(out_item.hit));
          check_field("accepted", longint'(oldest_result.accepted),
                      longint'(out_item.accepted));
          check_field("found_kind", longint'(oldest_result.found_kind),
                      longint'(out_item.found_kind));
          check_field("found_depth", longint'(oldest_result.found_depth),
                      longint'(out_item.found_depth));
          check_field("found_score", longint'(oldest_result.found_score),
                      longint'(out_item.found_score));
          check_field("found_move", longint'(oldest_result.found_move),
                      longint'(out_item.found_move));
          check_field("slots_filled", longint'(oldest_result.slots_filled),
                      longint'(out_item.slots_filled));
        end
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
        // long back-pressure so the core fills and drops in_ready
        out_ready <= 1'b0;
        stall_left = LONG_HOLD_CYCLES - 1;
        long_hold_done = 1'b1;
      end else if (!quiet_tail() && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles with no handshake on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [KEY_W-1:0] key_pool[KEY_POOL_SIZE];
    logic [SID_W-1:0] search_clock;
    in_item_t         req;
    int               roll;
    logic [KEY_W-1:0] all_ones;

    for (int s = 0; s < SLOT_COUNT; s++) mirror_valid[s] = 1'b0;
    mirror_filled = '0;
    all_ones = '1;

    // Directed requests.
    // empty table, then a fresh store and lookups around it
    pending_requests.push_back(make_request(OP_LOOKUP, 64'h0, 0, 100, 0, 0, 0));
    pending_requests.push_back(make_request(OP_STORE, 64'h0, 10, 100, 3, -32768, 16'hFFFF));
    pending_requests.push_back(make_request(OP_LOOKUP, 64'h0, 10, 101, 0, 0, 0));
    pending_requests.push_back(make_request(OP_LOOKUP, 64'h0, 11, 101, 0, 0, 0));
    // same slot, other tag: miss, then the replacement rule decides
    pending_requests.push_back(make_request(OP_LOOKUP, 64'h1000, 0, 101, 0, 0, 0));
    pending_requests.push_back(make_request(OP_STORE, 64'h1000, 8, 102, 1, 1234, 16'h0F0F));
    pending_requests.push_back(make_request(OP_STORE, 64'h1000, 8, 103, 2, -1, 16'hF0F0));
    pending_requests.push_back(make_request(OP_LOOKUP, 64'h0, 0, 103, 0, 0, 0));
    pending_requests.push_back(make_request(OP_LOOKUP, 64'h1000, 8, 104, 0, 0, 0));
    // top slot, field extremes, depth margin boundary
    pending_requests.push_back(make_request(OP_STORE, all_ones, 255, 65535, 0, 32767, 0));
    pending_requests.push_back(make_request(OP_LOOKUP, all_ones, 255, 65535, 3, 5, 7));
    pending_requests.push_back(make_request(OP_STORE, all_ones, 253, 65535, 1, 1, 1));
    pending_requests.push_back(make_request(OP_STORE, all_ones, 254, 65535, 2, 2, 2));
    // search number far below the stored age: negative difference, refused
    pending_requests.push_back(make_request(OP_STORE, all_ones, 0, 0, 3, 3, 3));
    pending_requests.push_back(make_request(OP_LOOKUP, all_ones, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_request(OP_STORE, all_ones, 0, 2, 1, -100, 16'h8000));
    // depth floor: a stored depth of 5 never protects, 6 does
    pending_requests.push_back(make_request(OP_STORE, 64'h5, 5, 200, 1, 50, 5));
    pending_requests.push_back(make_request(OP_STORE, 64'h5, 0, 200, 2, 51, 6));
    pending_requests.push_back(make_request(OP_STORE, 64'h6, 6, 300, 3, 60, 7));
    pending_requests.push_back(make_request(OP_STORE, 64'h6, 4, 300, 0, 61, 8));
    pending_requests.push_back(make_request(OP_STORE, 64'h6, 5, 300, 1, 62, 9));
    pending_requests.push_back(make_request(OP_LOOKUP, 64'h6, 5, 301, 0, 0, 0));
    pending_requests.push_back(make_request(OP_LOOKUP, 64'h8000_0000_0000_0006, 0, 301,
                                            0, 0, 0));
    pending_requests.push_back(make_request(OP_STORE, 64'hA5A5_5A5A_C3C3_3C3C, 77, 400,
                                            2, -12345, 16'h5A5A));

    // Small key pool, odd entries share a slot with their even neighbor,
    // so stores and lookups keep meeting the same slots.
    for (int k = 0; k < KEY_POOL_SIZE; k++) begin
      key_pool[k] = {$urandom, $urandom};
      if (k % 2 == 1) key_pool[k][11:0] = key_pool[k-1][11:0];
    end
    // start near the top so the search number wraps during the run
    search_clock = 16'(65500 + $urandom_range(0, 20));

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      roll = $urandom_range(0, 99);
      req.bound_kind = 2'($urandom);
      req.score      = 16'($urandom);
      req.move_code  = 16'($urandom);
      if (roll < 15) begin
        // noise: everything random
        req.op            = 1'($urandom);
        req.position_key  = {$urandom, $urandom};
        req.search_depth  = 8'($urandom);
        req.search_number = 16'($urandom);
      end else begin
        if ($urandom_range(0, 7) == 0) search_clock += 16'($urandom_range(1, 3));
        req.op            = $urandom_range(0, 1) ? OP_STORE : OP_LOOKUP;
        req.position_key  = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
        req.search_depth  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                        : 8'($urandom_range(0, 12));
        req.search_number = 16'(search_clock - $urandom_range(0, 1));
      end
      pending_requests.push_back(req);
    end
    total_requests = pending_requests.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_count < total_requests || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      mismatch_count++;
      $error("%0d results never arrived", expected_results.size());
    end

    $display("Covered %0d requests: %0d lookup hits, %0d misses, %0d stores written, %0d refused",
             accepted_count, hit_count, miss_count, write_count, refuse_count);
    $display("%0d results checked, %0d slots filled, %0d mismatches",
             results_seen, mirror_filled, mismatch_count);
    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
